[hw/rtl/tli_pkg.sv]
// Shared constants, codes and types of the timeline linear interpolator.
package tli_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLUMNS = 16;
    localparam int FRAC_BITS   = 16;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int CNT_W  = ROW_W + 1;
    localparam int VADR_W = ROW_W + COL_W;
    localparam int WGT_W  = FRAC_BITS + 2;
    localparam int PROD_W = 33 + WGT_W;

    localparam logic [PROD_W-1:0] HALF = (FRAC_BITS > 0) ?
        PROD_W'(64'd1 << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0)) : '0;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ST_INTERP     = 2'd0,
        ST_HOLD_LAST  = 2'd1,
        ST_HOLD_FIRST = 2'd2,
        ST_INVALID    = 2'd3
    } t_status;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_CHK     = 12'b000000000010,
        S_BACK    = 12'b000000000100,
        S_WALK_RD = 12'b000000001000,
        S_WALK_CK = 12'b000000010000,
        S_SETUP   = 12'b000000100000,
        S_T0      = 12'b000001000000,
        S_T1      = 12'b000010000000,
        S_DIV     = 12'b000100000000,
        S_COL_RD  = 12'b001000000000,
        S_COL_MUL = 12'b010000000000,
        S_COL_OUT = 12'b100000000000
    } t_state;

endpackage

[hw/rtl/timeline_linear_interpolator.sv]
// Top level of the timeline linear interpolator: table memories, cursor walk, divider, output.
//
// A load item writes one element of the time memory (column 0) or of the value memory
// (columns 1 to 16); other columns write nothing. A query first reads row 0 (an invalid
// table then gives its single error transfer), checks the remembered cursor against the row
// before it, and walks forward row by row, each step waiting on the registered read of the
// time memory. An interpolating query then reads both neighbor times and runs a radix-2
// divider for the weight. Each value column passes through a dual-port read of the value
// memory, one registered multiply, and the output register load. A held row skips the
// neighbor reads and the divider. A stalled output holds the query at its output load.
// The last result waits in the output register while the next item is taken.
module timeline_linear_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_row,
    input  logic [4:0]  i_column,
    input  logic signed [31:0] i_load_value,
    input  logic signed [31:0] i_query_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_value_column,
    output logic signed [31:0] o_result_value,
    output logic        o_last,
    output logic [1:0]  o_status
);
    import tli_pkg::*;

    logic signed [31:0] r_times_mem [MAX_ROWS];
    logic signed [31:0] r_values_mem [MAX_ROWS*MAX_COLUMNS];

    t_state r_state;
    logic [8:0]  r_rows_cfg;
    logic [4:0]  r_cols_cfg;
    logic [CNT_W-1:0] r_cursor, r_idx, r_n;
    logic [COL_W:0]   r_cols;
    logic [COL_W-1:0] r_col;
    logic signed [31:0] r_t, r_t0, r_t_rd, r_v0_rd, r_v1_rd, r_v1;
    logic [ROW_W-1:0] r_row0, r_row1;
    logic [1:0]  r_stat;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [FRAC_BITS-1:0] r_qlo;
    logic        r_q16;
    logic [4:0]  r_cnt;
    logic signed [WGT_W-1:0]  r_weight;
    logic signed [PROD_W-1:0] r_prod;
    logic        r_out_valid;
    logic [3:0]  r_out_col;
    logic signed [31:0] r_out_val;
    logic        r_out_last;
    logic [1:0]  r_out_stat;

    logic in_fire, out_free, col_last, out_load;
    logic [CNT_W-1:0] n_n, idx_clamp, idx_m1;
    logic [COL_W:0] n_cols;
    logic [ROW_W-1:0] t_addr;
    logic signed [32:0] d_num, d_den;
    logic [33:0] rem2;
    logic signed [PROD_W-1:0] rounded;
    logic signed [31:0] interp;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign out_load    = (r_state == S_COL_OUT) && out_free;
    assign col_last    = ({1'b0, r_col} + 1'b1) == r_cols;

    assign o_out_valid    = r_out_valid;
    assign o_value_column = r_out_col;
    assign o_result_value = r_out_val;
    assign o_last         = r_out_last;
    assign o_status       = r_out_stat;

    always_comb begin
        n_n = (r_rows_cfg > 9'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(r_rows_cfg);
        if (r_cols_cfg == 5'd0) begin
            n_cols = (COL_W+1)'(1);
        end else if (r_cols_cfg > 5'(MAX_COLUMNS)) begin
            n_cols = (COL_W+1)'(MAX_COLUMNS);
        end else begin
            n_cols = (COL_W+1)'(r_cols_cfg);
        end
        idx_clamp = (r_cursor > r_n) ? r_n : r_cursor;
        idx_m1    = r_idx - 1'b1;
        case (r_state)
            S_CHK:     t_addr = ROW_W'(idx_clamp - 1'b1);
            S_WALK_RD: t_addr = r_idx[ROW_W-1:0];
            S_SETUP:   t_addr = idx_m1[ROW_W-1:0];
            S_T0:      t_addr = r_idx[ROW_W-1:0];
            default:   t_addr = '0;
        endcase
        d_num   = {r_t_rd[31], r_t_rd} - {r_t[31], r_t};
        d_den   = {r_t_rd[31], r_t_rd} - {r_t0[31], r_t0};
        rem2    = {r_rem[32:0], 1'b0};
        rounded = (r_prod + $signed(HALF)) >>> FRAC_BITS;
        interp  = r_v1 + rounded[31:0];
    end

    // Table memories: one write port, registered reads.
    always_ff @(posedge i_clk) begin
        if (in_fire && i_kind == KIND_LOAD && i_column == 5'd0) begin
            r_times_mem[i_row] <= i_load_value;
        end
        r_t_rd <= r_times_mem[t_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_kind == KIND_LOAD && i_column != 5'd0
                && i_column <= 5'(MAX_COLUMNS)) begin
            r_values_mem[{i_row, COL_W'(i_column - 5'd1)}] <= i_load_value;
        end
        r_v0_rd <= r_values_mem[{r_row0, r_col}];
        r_v1_rd <= r_values_mem[{r_row1, r_col}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= '0;
            r_cols_cfg <= 5'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ROWS) begin
                r_rows_cfg <= i_cfg_data[8:0];
            end else begin
                r_cols_cfg <= i_cfg_data[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire && i_kind == KIND_QUERY) begin
                        r_t    <= i_query_time;
                        r_n    <= n_n;
                        r_cols <= n_cols;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    // r_t_rd holds the time of row 0
                    if (r_n == '0 || r_t_rd != 32'sd0) begin
                        r_stat  <= ST_INVALID;
                        r_col   <= '0;
                        r_cols  <= (COL_W+1)'(1);
                        r_prod  <= '0;
                        r_v1    <= '0;
                        r_state <= S_COL_OUT;
                    end else begin
                        r_idx   <= idx_clamp;
                        r_state <= (idx_clamp != '0) ? S_BACK : S_WALK_RD;
                    end
                end
                S_BACK: begin
                    // restart from row 0 when the query went back in time
                    if (r_t_rd > r_t) begin
                        r_idx <= '0;
                    end
                    r_state <= S_WALK_RD;
                end
                S_WALK_RD: begin
                    r_state <= (r_idx < r_n) ? S_WALK_CK : S_SETUP;
                end
                S_WALK_CK: begin
                    if (r_t_rd <= r_t) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_WALK_RD;
                    end else begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_cursor <= r_idx;
                    r_col    <= '0;
                    r_weight <= '0;
                    if (r_idx == '0) begin
                        r_stat  <= ST_HOLD_FIRST;
                        r_row0  <= '0;
                        r_row1  <= '0;
                        r_state <= S_COL_RD;
                    end else if (r_idx >= r_n) begin
                        r_stat  <= ST_HOLD_LAST;
                        r_row0  <= ROW_W'(r_n - 1'b1);
                        r_row1  <= ROW_W'(r_n - 1'b1);
                        r_state <= S_COL_RD;
                    end else begin
                        r_stat  <= ST_INTERP;
                        r_row0  <= idx_m1[ROW_W-1:0];
                        r_row1  <= r_idx[ROW_W-1:0];
                        r_state <= S_T0;
                    end
                end
                S_T0: begin
                    r_t0    <= r_t_rd;
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_den <= d_den;
                    if (d_num == d_den) begin
                        r_q16 <= 1'b1;
                        r_rem <= '0;
                    end else begin
                        r_q16 <= 1'b0;
                        r_rem <= {1'b0, d_num};
                    end
                    r_qlo   <= '0;
                    r_cnt   <= 5'(FRAC_BITS);
                    r_state <= (FRAC_BITS > 0) ? S_DIV : S_COL_RD;
                    if (FRAC_BITS == 0) begin
                        r_weight <= WGT_W'(d_num == d_den);
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    if (rem2 >= {1'b0, r_den}) begin
                        r_rem <= rem2 - {1'b0, r_den};
                        r_qlo <= {r_qlo[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= rem2;
                        r_qlo <= {r_qlo[FRAC_BITS-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 5'd1) begin
                        r_weight <= r_q16 ? $signed(WGT_W'(64'd1 << FRAC_BITS))
                            : $signed(WGT_W'({r_qlo[FRAC_BITS-2:0],
                                             rem2 >= {1'b0, r_den}}));
                        r_state <= S_COL_RD;
                    end
                end
                S_COL_RD: begin
                    r_state <= S_COL_MUL;
                end
                S_COL_MUL: begin
                    r_prod  <= ($signed({r_v0_rd[31], r_v0_rd})
                                - $signed({r_v1_rd[31], r_v1_rd})) * r_weight;
                    r_v1    <= r_v1_rd;
                    r_state <= S_COL_OUT;
                end
                S_COL_OUT: begin
                    if (out_free) begin
                        r_out_col   <= 4'(r_col);
                        r_out_val   <= interp;
                        r_out_last  <= col_last;
                        r_out_stat  <= r_stat;
                        if (col_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= S_COL_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
